// ===== design/tsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, constants and the deletion test for the thinning sub-pass
// filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

  // Default geometry limits.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Smallest usable frame dimension.
  localparam int MIN_DIM = 4;

  // Width of the frame_width and frame_height registers.
  localparam int CFG_DIM_W = 11;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SUBPASS      = 2'd2;

  // Reset values of the registers.
  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Item kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Line buffer entry: bit 1 is the upper line, bit 0 the middle line.
  localparam int LB_W = 2;

  typedef struct packed {
    logic kind;
    logic pixel_in;
  } tsf_in_t;

  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic frame_end;
    logic frame_changed;
  } tsf_out_t;

  // Zhang-Suen deletion test on a 3x3 window. Bit c*3+r holds column c
  // (0 left) and row r (0 top); the center is bit 4.
  function automatic logic tsf_delete(input logic [8:0] win, input logic subpass);
    logic       n, ne, e, se, s, sw, wv, nw;
    logic [7:0] ring;
    logic [3:0] trans;
    logic [3:0] count;
    logic       m1, m2;
    n  = win[3];
    ne = win[6];
    e  = win[7];
    se = win[8];
    s  = win[5];
    sw = win[2];
    wv = win[1];
    nw = win[0];
    ring = {nw, wv, sw, s, se, e, ne, n};
    trans = '0;
    count = '0;
    // Count 0-to-1 steps clockwise round the ring and the set neighbours.
    for (int i = 0; i < 8; i++) begin
      if (!ring[i] && ring[(i + 1) % 8]) begin
        trans = trans + 4'd1;
      end
      count = count + 4'(ring[i]);
    end
    if (subpass == 1'b0) begin
      m1 = n & e & s;
      m2 = e & s & wv;
    end else begin
      m1 = n & e & wv;
      m2 = n & s & wv;
    end
    return (trans == 4'd1) && (count >= 4'd2) && (count <= 4'd6) && !m1 && !m2;
  endfunction

endpackage

// ===== design/tsf_line_buf.sv =====
// ----------------------------------------------------------------------------
// tsf_line_buf
// Two-line pixel buffer in one memory, with a registered read and a bypass
// for a read that hits the address written in the same cycle.
// ----------------------------------------------------------------------------
module tsf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [tsf_pkg::LB_W-1:0] wr_data_i,
  output logic [tsf_pkg::LB_W-1:0] rd_data_o
);
  import tsf_pkg::*;

  logic [LB_W-1:0] mem [DEPTH];
  logic [LB_W-1:0] rd_q;
  logic [LB_W-1:0] fwd_data_q;
  logic            fwd_q;

  // Memory write and registered read; the read sees the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Remember whether the read collided with the write of the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== design/thinning_subpass_filter_top.sv =====
// ----------------------------------------------------------------------------
// thinning_subpass_filter_top
// One Zhang-Suen thinning sub-pass over a raster stream of binary pixels.
// It takes one item per clock while the result channel is not stalled. A
// pixel result comes out frame_width+1 pixel items after it went in, and
// reaches the output register through the line buffer's registered read
// and the window and deletion stage. Interior foreground pixels are
// deleted by the usual test on the original frame, border pixels pass
// unchanged, and after the last pixel of a frame flush items drain the
// remaining frame_width+1 results. frame_changed comes with frame_end.
// Writing frame_width or frame_height restarts the stream; subpass applies
// to later decisions. The line buffers need no clearing after reset.
// ----------------------------------------------------------------------------
module thinning_subpass_filter_top #(
  parameter int MAX_WIDTH  = tsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Pixel input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tsf_pkg::tsf_in_t            in_data_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tsf_pkg::tsf_out_t           out_data_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsf_pkg::PADDR_W-1:0] paddr,
  input  logic [tsf_pkg::PDATA_W-1:0] pwdata,
  output logic [tsf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tsf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int EW = (CFG_DIM_W > $clog2(MAX_WIDTH + 1)) ? CFG_DIM_W : $clog2(MAX_WIDTH + 1);
  localparam int EH = (CFG_DIM_W > $clog2(MAX_HEIGHT + 1)) ? CFG_DIM_W :
                      $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = $clog2(MAX_WIDTH + 2);

  // Configuration registers.
  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic                 subpass_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 restart;

  // Stream position state.
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Effective geometry.
  logic [EW-1:0] eff_w, w_last;
  logic [EH-1:0] eff_h, h_last;
  logic [EW:0]   w_plus1;

  // Input stage decode.
  logic             adv, accept, is_flush;
  logic             pix_emit, flush_emit, emit;
  logic             in_last_col, in_last_row, out_last_col, out_last_row;
  logic             border, fend;
  logic [COL_W-1:0] rd_addr;

  // Window stage registers.
  logic             s1_valid_q, s1_flush_q, s1_pixel_q, s1_emit_q;
  logic             s1_border_q, s1_fend_q, s1_src_mid_q;
  logic [COL_W-1:0] s1_addr_q;
  logic [8:0]       win_q, new_win;
  logic             any_q, any_or;
  logic [LB_W-1:0]  lb_rd;
  logic             top, mid, center, cond, rem, lb_wr_en;

  // Output register.
  logic     out_valid_q;
  tsf_out_t out_q;

  // Configuration port decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign restart = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= FRAME_WIDTH_RST;
      height_q  <= FRAME_HEIGHT_RST;
      subpass_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  width_q   <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: height_q  <= pwdata[CFG_DIM_W-1:0];
        REG_SUBPASS:      subpass_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
      REG_SUBPASS:      prdata = PDATA_W'(subpass_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp the geometry to the supported range.
  always_comb begin
    if (EW'(width_q) < EW'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    if (EH'(height_q) < EH'(MIN_DIM)) begin
      eff_h = EH'(MIN_DIM);
    end else if (EH'(height_q) > EH'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(height_q);
    end
  end

  assign w_last  = eff_w - EW'(1);
  assign h_last  = eff_h - EH'(1);
  assign w_plus1 = (EW + 1)'(eff_w) + (EW + 1)'(1);

  // The whole pipe moves when the output register can take a new item.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign is_flush   = (in_data_i.kind == KIND_FLUSH);

  // Positions and the release decision for the arriving item.
  assign in_last_col  = (EW'(in_col_q) == w_last);
  assign in_last_row  = (EH'(in_row_q) == h_last);
  assign out_last_col = (EW'(out_col_q) == w_last);
  assign out_last_row = (EH'(out_row_q) == h_last);
  assign pix_emit     = ((EW + 1)'(cnt_q) >= w_plus1);
  assign flush_emit   = (in_col_q == '0) && (in_row_q == '0) && (cnt_q != '0);
  assign emit         = is_flush ? flush_emit : pix_emit;
  assign border       = (out_row_q == '0) || out_last_row || (out_col_q == '0) || out_last_col;
  assign fend         = out_last_row && out_last_col;
  assign rd_addr      = is_flush ? out_col_q : in_col_q;

  // Next positions and pending count.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    cnt_d     = cnt_q;
    if (!is_flush) begin
      if (in_last_col) begin
        in_col_d = '0;
        in_row_d = in_last_row ? '0 : in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end
    if (emit) begin
      if (out_last_col) begin
        out_col_d = '0;
        out_row_d = out_last_row ? '0 : out_row_q + ROW_W'(1);
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end
    if (!is_flush && !pix_emit) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (is_flush && flush_emit) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      cnt_q     <= '0;
    end else if (restart) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      cnt_q     <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      cnt_q     <= cnt_d;
    end
  end

  // Window stage pipeline register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_flush_q   <= is_flush;
      s1_pixel_q   <= in_data_i.pixel_in;
      s1_emit_q    <= emit;
      s1_border_q  <= border;
      s1_fend_q    <= fend;
      s1_src_mid_q <= out_last_row;
      s1_addr_q    <= rd_addr;
    end
  end

  // Line buffer: the column shifts down one line as each pixel arrives.
  assign lb_wr_en = adv && s1_valid_q && !s1_flush_q;

  tsf_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .rd_addr_i (rd_addr),
    .wr_en_i   (lb_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({mid, s1_pixel_q}),
    .rd_data_o (lb_rd)
  );

  // Window shift and deletion decision.
  assign top     = lb_rd[1];
  assign mid     = lb_rd[0];
  assign new_win = {s1_pixel_q, mid, top, win_q[8:3]};
  assign center  = s1_flush_q ? (s1_src_mid_q ? mid : top) : new_win[4];
  assign cond    = tsf_delete(new_win, subpass_q);
  assign rem     = !s1_flush_q && !s1_border_q && center && cond;
  assign any_or  = any_q | rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      any_q <= 1'b0;
    end else if (restart) begin
      win_q <= '0;
      any_q <= 1'b0;
    end else if (adv && s1_valid_q) begin
      if (!s1_flush_q) begin
        win_q <= new_win;
      end
      if (s1_emit_q) begin
        any_q <= s1_fend_q ? 1'b0 : any_or;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && s1_emit_q) begin
      out_q.pixel_out     <= center & ~rem;
      out_q.removed       <= rem;
      out_q.frame_end     <= s1_fend_q;
      out_q.frame_changed <= s1_fend_q & any_or;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The pending count never exceeds one row plus one pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (EW + 1)'(cnt_q) <= w_plus1)
    else $error("pending count exceeds one row plus one pixel");

  // Items drained by flush are border pixels and are never deleted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_flush_q |-> !rem)
    else $error("flush item produced a deletion");

  // A delivered change flag only comes with the end of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.frame_end |-> !out_q.frame_changed)
    else $error("frame_changed without frame_end");

  // A deleted pixel is delivered as background.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.removed |-> !out_q.pixel_out)
    else $error("removed pixel delivered as foreground");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thinning sub-pass filter testbench
// Streams binary frames of many sizes through the filter, with random gaps
// on the input and random stalls on the output. A scoreboard mirrors the line
// buffers, the 3x3 window and the stream positions, predicts every released
// pixel and compares each result field by field. Registers are set and read
// back between phases, including clamped sizes and both sub-passes.
// ----------------------------------------------------------------------------

// Mirrors the filter and holds the pixels it is expected to release.
class thinning_checker;
  localparam int unsigned LINE_DEPTH = tsf_pkg::MAX_WIDTH_DEF;

  logic [tsf_pkg::CFG_DIM_W-1:0] width_reg;
  logic [tsf_pkg::CFG_DIM_W-1:0] height_reg;
  logic                          subpass_reg;

  bit          upper_line_q [LINE_DEPTH];
  bit          middle_line_q[LINE_DEPTH];
  bit [8:0]    window_q;
  int unsigned in_col, in_row, out_col, out_row;
  bit          any_removed_q;

  tsf_pkg::tsf_out_t expected_pixels[$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned items_seen;
  int unsigned removals;
  int unsigned changed_frames;

  function new();
    width_reg   = tsf_pkg::FRAME_WIDTH_RST;
    height_reg  = tsf_pkg::FRAME_HEIGHT_RST;
    subpass_reg = 1'b0;
    foreach (upper_line_q[i]) begin
      upper_line_q[i]  = 1'b0;
      middle_line_q[i] = 1'b0;
    end
    restart_stream();
  endfunction

  function void restart_stream();
    window_q      = '0;
    in_col        = 0;
    in_row        = 0;
    out_col       = 0;
    out_row       = 0;
    any_removed_q = 1'b0;
  endfunction

  function int unsigned clamp_dim(logic [tsf_pkg::CFG_DIM_W-1:0] v, int unsigned hi);
    if (v < tsf_pkg::MIN_DIM) return tsf_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function int unsigned eff_width();
    return clamp_dim(width_reg, tsf_pkg::MAX_WIDTH_DEF);
  endfunction

  function int unsigned eff_height();
    return clamp_dim(height_reg, tsf_pkg::MAX_HEIGHT_DEF);
  endfunction

  // Register write as the block applies it; size changes restart the stream.
  function void write_reg(logic [tsf_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      tsf_pkg::REG_FRAME_WIDTH: begin
        width_reg = value[tsf_pkg::CFG_DIM_W-1:0];
        restart_stream();
      end
      tsf_pkg::REG_FRAME_HEIGHT: begin
        height_reg = value[tsf_pkg::CFG_DIM_W-1:0];
        restart_stream();
      end
      tsf_pkg::REG_SUBPASS: begin
        subpass_reg = value[0];
      end
      default: begin
      end
    endcase
  endfunction

  function logic [31:0] reg_value(logic [tsf_pkg::REG_IDX_W-1:0] idx);
    case (idx)
      tsf_pkg::REG_FRAME_WIDTH:  return 32'(width_reg);
      tsf_pkg::REG_FRAME_HEIGHT: return 32'(height_reg);
      default:                   return 32'(subpass_reg);
    endcase
  endfunction

  // Pixels stored but not yet released, counted round the frame.
  function int unsigned pixels_held();
    int unsigned w, total;
    w     = eff_width();
    total = w * eff_height();
    return ((in_row * w + in_col) + total - (out_row * w + out_col)) % total;
  endfunction

  function int unsigned outstanding();
    return expected_pixels.size();
  endfunction

  // Deletion test on the current window; ring runs N, NE, E, SE, S, SW, W, NW.
  function bit deletable();
    bit [7:0]    ring;
    int unsigned rises, set_bits;
    bit          north, east, south, west, prod_a, prod_b;
    north = window_q[3];
    east  = window_q[7];
    south = window_q[5];
    west  = window_q[1];
    ring  = {window_q[0], west, window_q[2], south, window_q[8], east, window_q[6], north};
    rises    = 0;
    set_bits = 0;
    for (int i = 0; i < 8; i++) begin
      if (!ring[i] && ring[(i + 1) % 8]) rises++;
      if (ring[i]) set_bits++;
    end
    if (!subpass_reg) begin
      prod_a = north & east & south;
      prod_b = east & south & west;
    end else begin
      prod_a = north & east & west;
      prod_b = north & south & west;
    end
    return rises == 1 && set_bits >= 2 && set_bits <= 6 && !prod_a && !prod_b;
  endfunction

  // Works out the next released pixel and moves the output position on.
  function void release_pixel(bit center, bit may_decide);
    tsf_pkg::tsf_out_t res;
    int unsigned       w, h;
    bit                on_border;
    w = eff_width();
    h = eff_height();
    res.pixel_out     = center;
    res.removed       = 1'b0;
    res.frame_end     = 1'b0;
    res.frame_changed = 1'b0;
    on_border = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
    if (!on_border && may_decide && center && deletable()) begin
      res.removed   = 1'b1;
      res.pixel_out = 1'b0;
      removals++;
    end
    any_removed_q |= res.removed;
    if (out_row == h - 1 && out_col == w - 1) begin
      res.frame_end     = 1'b1;
      res.frame_changed = any_removed_q;
      if (any_removed_q) changed_frames++;
      any_removed_q = 1'b0;
    end
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    expected_pixels.insert(expected_pixels.size(), res);
  endfunction

  // Called for every item the block accepts.
  function void note_input(tsf_pkg::tsf_in_t item);
    int unsigned w, h, col;
    bit          top, mid;
    w = eff_width();
    h = eff_height();
    items_seen++;
    if (item.kind == tsf_pkg::KIND_PIXEL) begin
      col = in_col % LINE_DEPTH;
      top = upper_line_q[col];
      mid = middle_line_q[col];
      upper_line_q[col]  = mid;
      middle_line_q[col] = item.pixel_in;
      window_q = {item.pixel_in, mid, top, window_q[8:3]};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (pixels_held() >= w + 2) release_pixel(window_q[4], 1'b1);
    end else if (in_col == 0 && in_row == 0 && pixels_held() != 0) begin
      // A flush at the frame boundary drains one tail pixel from the lines.
      col = out_col % LINE_DEPTH;
      release_pixel((out_row == h - 1) ? middle_line_q[col] : upper_line_q[col], 1'b0);
    end
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Compares one accepted result with the oldest expected pixel.
  task check_pixel(tsf_pkg::tsf_out_t got);
    tsf_pkg::tsf_out_t exp;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("result %b arrived with nothing expected", got));
      return;
    end
    exp = expected_pixels[0];
    expected_pixels.delete(0);
    results_checked++;
    if (got.pixel_out !== exp.pixel_out)
      report_mismatch($sformatf("pixel_out %b, expected %b", got.pixel_out, exp.pixel_out));
    if (got.removed !== exp.removed)
      report_mismatch($sformatf("removed %b, expected %b", got.removed, exp.removed));
    if (got.frame_end !== exp.frame_end)
      report_mismatch($sformatf("frame_end %b, expected %b", got.frame_end, exp.frame_end));
    if (got.frame_changed !== exp.frame_changed)
      report_mismatch($sformatf("frame_changed %b, expected %b",
                                got.frame_changed, exp.frame_changed));
  endtask
endclass

module tb;
  import tsf_pkg::*;

  localparam int unsigned CLK_HALF       = 6;
  localparam longint      LIMIT_CYCLES   = 1_500_000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_ITEMS   = 200;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Square of foreground in the middle of a 4x4 frame, bit r*4+c.
  localparam logic [15:0] DIRECTED_IMG   = 16'h0660;

  typedef enum int {STYLE_NOISE, STYLE_BLOCK, STYLE_SOLID, STYLE_EMPTY} frame_style_e;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  tsf_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tsf_out_t           out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  thinning_checker sb = new();

  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  bit          hold_request    = 1'b0;
  int unsigned stimulus_items  = 0;
  int unsigned input_held      = 0;
  int unsigned phases_run      = 0;

  thinning_subpass_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Results are checked before the same edge's input is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_pixel(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (in_valid_i && in_stall_o) input_held++;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one item, after an optional gap, and waits until it is taken.
  task automatic send_item(input logic kind, input logic pix);
    tsf_in_t     item;
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    item.kind     = kind;
    item.pixel_in = pix;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits for every expected pixel, then lets the pipeline settle.
  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got !== sb.reg_value(idx))
      sb.report_mismatch($sformatf("register %0d reads %h, expected %h",
                                   idx, got, sb.reg_value(idx)));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sets all registers, sometimes pokes the unused slot, and reads back.
  task automatic configure(input logic [31:0] wv, input logic [31:0] hv, input logic [31:0] sv);
    reg_write(REG_FRAME_WIDTH, wv);
    reg_write(REG_FRAME_HEIGHT, hv);
    reg_write(REG_SUBPASS, sv);
    if ($urandom_range(0, 3) == 0) reg_write(REG_UNUSED, $urandom());
    reg_check(REG_FRAME_WIDTH);
    reg_check(REG_FRAME_HEIGHT);
    reg_check(REG_SUBPASS);
    phases_run++;
  endtask

  // One frame in raster order, with the odd stray flush in between.
  task automatic send_frame(input int unsigned fw, input int unsigned fh,
                            input frame_style_e style);
    int unsigned density, r0, r1, c0, c1;
    logic        pix;
    density = $urandom_range(20, 80);
    r0 = $urandom_range(0, fh - 1);
    r1 = $urandom_range(r0, fh - 1);
    c0 = $urandom_range(0, fw - 1);
    c1 = $urandom_range(c0, fw - 1);
    for (int unsigned r = 0; r < fh; r++) begin
      for (int unsigned c = 0; c < fw; c++) begin
        case (style)
          STYLE_NOISE: pix = $urandom_range(0, 99) < density;
          STYLE_BLOCK: pix = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^
                             ($urandom_range(0, 99) < 3);
          STYLE_SOLID: pix = 1'b1;
          default:     pix = 1'b0;
        endcase
        if ($urandom_range(0, 99) < 3) send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
        send_item(KIND_PIXEL, pix);
        stimulus_items++;
      end
    end
  endtask

  // Full frames under one setting, then flushes that empty the tail.
  task automatic run_phase(input logic [31:0] wv, input logic [31:0] hv,
                           input logic [31:0] sv, input int unsigned nframes);
    int unsigned fw, fh, partial;
    configure(wv, hv, sv);
    fw = sb.eff_width();
    fh = sb.eff_height();
    for (int unsigned f = 0; f < nframes; f++) begin
      // A partial drain between frames before the next frame arrives.
      if (f != 0 && $urandom_range(0, 2) == 0) begin
        partial = $urandom_range(1, fw + 1);
        repeat (partial) send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
        stimulus_items += partial;
      end
      send_frame(fw, fh, frame_style_e'($urandom_range(0, 3)));
    end
    repeat (fw + 1 + $urandom_range(0, 2)) send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
    stimulus_items += fw + 1;
    stop_input();
    wait_drained();
  endtask

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  function automatic logic [31:0] random_dim();
    logic [31:0] v;
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 3);
    else v = $urandom_range(4, 12);
    if ($urandom_range(0, 1) == 1) v = v | ($urandom() & 32'hFFFF_F800);
    return v;
  endfunction

  initial begin
    int unsigned random_start;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a 4x4 frame whose middle square is deleted entirely, with
    // stray flushes before the frame, mid-frame and after the tail.
    configure(32'd4, 32'd4, 32'd0);
    send_item(KIND_FLUSH, 1'b1);
    for (int i = 0; i < 16; i++) begin
      if (i == 8) send_item(KIND_FLUSH, 1'b0);
      send_item(KIND_PIXEL, DIRECTED_IMG[i]);
    end
    for (int i = 0; i < 6; i++) send_item(KIND_FLUSH, i[0]);
    stop_input();
    wait_drained();

    // The result side holds off while items keep coming.
    send_idle_pct = 0;
    stall_pct     = 10;
    hold_request  = 1'b1;
    run_phase(32'd10, 32'd8, 32'd1, 2);

    // Random settings and frames, mostly small.
    random_start = stimulus_items;
    while (stimulus_items - random_start < RANDOM_ITEMS) begin
      send_idle_pct = pick_idle_pct();
      stall_pct     = pick_idle_pct();
      run_phase(random_dim(), random_dim(), $urandom(), $urandom_range(1, 3));
    end

    // Closing stretch at full rate.
    send_idle_pct = 0;
    stall_pct     = 0;
    run_phase(32'd7, 32'd5, 32'd0, 2);
    run_phase(32'd6, 32'd9, 32'd1, 2);

    for (int i = 0; i < 5000 && sb.outstanding() != 0; i++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d expected pixels never arrived", sb.outstanding()));

    $display("Covered %0d items over %0d settings; %0d results checked, %0d removals.",
             sb.items_seen, phases_run, sb.results_checked, sb.removals);
    $display("Frames with changes: %0d; input held back on %0d cycles.",
             sb.changed_frames, input_held);
    if (sb.mismatches == 0) begin
      $display("[thinning_subpass_filter_top] OK");
    end else begin
      $display("[thinning_subpass_filter_top] ERROR");
    end
    $finish;
  end

  // Guard against a hung stream.
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout with %0d expected pixels outstanding", sb.outstanding());
    $display("[thinning_subpass_filter_top] ERROR");
    $finish;
  end
endmodule
